@@ sv/fmp_pkg.sv @@
// ============================================================================
// fmp_pkg
// Shared types and constants for the framed message parser: frame marker
// bytes, event codes and the parser phase encoding.
// ============================================================================
`default_nettype none

package fmp_pkg;

  localparam int unsigned RxBufferBytesDefault = 4096;
  localparam int unsigned FrameOverhead        = 10;
  localparam int unsigned MaxLenWidth          = 12;

  localparam logic [7:0] StartByte = 8'hA5;
  localparam logic [7:0] EndByte   = 8'h5A;
  localparam logic [7:0] CloseByte = 8'h04;

  typedef enum logic [2:0] {
    EV_HEADER_DONE = 3'd0,
    EV_CONTENT     = 3'd1,
    EV_MSG_DONE    = 3'd2,
    EV_CLOSE       = 3'd3,
    EV_BAD_START   = 3'd4,
    EV_BAD_END     = 3'd5,
    EV_TOO_LONG    = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_CONTENT = 4'b0100,
    PH_END     = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

@@ sv/framed_message_parser_core.sv @@
// ============================================================================
// framed_message_parser_core
// Deframes a byte stream into messages: start byte, 32-bit identifier,
// 32-bit content length, content bytes and end byte. Reports header,
// content bytes, message completion, session close and framing errors.
// ============================================================================
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ----------------------------------
//  in       sink       in_valid_i/in_stall_o  rx_byte_i, restart_i
//  out      source     out_valid_o/out_stall_i event_res_o, msg_id_o,
//                                             content_len_o, data_byte_o,
//                                             byte_index_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (max_content_len)
//
//  An accepted byte is captured in an input register and is parsed from there
//  once the output can take a result; its result (if any) is then held in the
//  result register. One byte is accepted every clock while the output is not
//  stalled; the parse stage and the result register advance together.
//  A stall on the output holds the result register and the input register
//  and raises in_stall_o once the input register is occupied.
//  Reset clears the parser to expect a start byte and loads the length
//  limit with its default value.
// ============================================================================
`default_nettype none

module framed_message_parser_core #(
  parameter int unsigned RX_BUFFER_BYTES = fmp_pkg::RxBufferBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        restart_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [31:0]      msg_id_o,
  output logic [31:0]      content_len_o,
  output logic [7:0]       data_byte_o,
  output logic [11:0]      byte_index_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_data_i
);
  import fmp_pkg::*;

  localparam int unsigned BufLimitInt = RX_BUFFER_BYTES - FrameOverhead;
  localparam logic [31:0] BufLimit    = 32'(BufLimitInt);
  localparam logic [MaxLenWidth-1:0] DefaultLimit =
    (BufLimitInt > 4095) ? MaxLenWidth'(4095) : MaxLenWidth'(BufLimitInt);

  // Configuration register
  logic [MaxLenWidth-1:0] max_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= DefaultLimit;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       restart_q;
  logic       out_ready;
  logic       parse_fire;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_ready;
  assign parse_fire = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q    <= rx_byte_i;
      restart_q <= restart_i;
    end
  end

  // Parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] id_q, id_d;
  logic [31:0] len_q, len_d;
  logic [11:0] cnt_q, cnt_d;
  logic        halted_q, halted_d;

  // Result of the current parse
  logic        emit;
  event_e      ev;
  logic [31:0] res_id;
  logic [31:0] res_len;
  logic [7:0]  res_data;
  logic [11:0] res_idx;

  logic [31:0] len_full;
  logic [12:0] cnt_next;

  assign len_full = {len_q[23:0], byte_q};
  assign cnt_next = {1'b0, cnt_q} + 13'd1;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    id_d      = id_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    halted_d  = halted_q;
    emit      = 1'b0;
    ev        = EV_HEADER_DONE;
    res_id    = '0;
    res_len   = '0;
    res_data  = '0;
    res_idx   = '0;

    if (restart_q) begin
      phase_d   = PH_START;
      hdr_cnt_d = '0;
      id_d      = '0;
      len_d     = '0;
      cnt_d     = '0;
      halted_d  = 1'b0;
    end else if (!halted_q) begin
      unique case (phase_q)
        PH_START: begin
          if (byte_q == StartByte) begin
            phase_d   = PH_HEADER;
            hdr_cnt_d = '0;
            id_d      = '0;
            len_d     = '0;
            cnt_d     = '0;
          end else begin
            halted_d = 1'b1;
            emit     = 1'b1;
            if (byte_q == CloseByte) begin
              ev = EV_CLOSE;
            end else begin
              ev       = EV_BAD_START;
              res_data = byte_q;
            end
          end
        end
        PH_HEADER: begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (!hdr_cnt_q[2]) begin
            id_d = {id_q[23:0], byte_q};
          end else begin
            len_d = len_full;
          end
          // The eighth header byte completes the length field.
          if (hdr_cnt_q == 4'd7) begin
            emit    = 1'b1;
            res_id  = id_q;
            res_len = len_full;
            if (len_full > {20'd0, max_len_q} || len_full > BufLimit) begin
              halted_d = 1'b1;
              ev       = EV_TOO_LONG;
            end else begin
              ev      = EV_HEADER_DONE;
              cnt_d   = '0;
              phase_d = (len_full == 32'd0) ? PH_END : PH_CONTENT;
            end
          end
        end
        PH_CONTENT: begin
          cnt_d    = cnt_next[11:0];
          emit     = 1'b1;
          ev       = EV_CONTENT;
          res_id   = id_q;
          res_len  = len_q;
          res_data = byte_q;
          res_idx  = cnt_q;
          if ({19'd0, cnt_next} >= len_q) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          emit = 1'b1;
          if (byte_q == EndByte) begin
            ev        = EV_MSG_DONE;
            res_id    = id_q;
            res_len   = len_q;
            phase_d   = PH_START;
            hdr_cnt_d = '0;
            cnt_d     = '0;
          end else begin
            ev       = EV_BAD_END;
            res_data = byte_q;
            halted_d = 1'b1;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      hdr_cnt_q <= '0;
      id_q      <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      halted_q  <= 1'b0;
    end else if (parse_fire) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      id_q      <= id_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      halted_q  <= halted_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready) begin
      out_valid_o <= parse_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (parse_fire && emit) begin
      event_res_o   <= ev;
      msg_id_o      <= res_id;
      content_len_o <= res_len;
      data_byte_o   <= res_data;
      byte_index_o  <= res_idx;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_framed_message_parser_core.sv @@
// ============================================================================
// tb_framed_message_parser_core
// Self-checking testbench for the framed message parser. Bytes are pushed in
// under random sender gaps and receiver stalls. An in-bench parser predicts
// each result on acceptance, and a monitor compares the results that come out
// field by field, in order. The length limit is swept across several values.
// ============================================================================

module tb_framed_message_parser_core;
  import fmp_pkg::*;

  localparam int unsigned BufLimit  = RxBufferBytesDefault - FrameOverhead;
  localparam int unsigned MaxCycles = 400000;

  typedef struct packed {
    event_e      code;
    logic [31:0] id;
    logic [31:0] len;
    logic [7:0]  data;
    logic [11:0] idx;
  } frame_event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  event_res_o;
  logic [31:0] msg_id_o;
  logic [31:0] content_len_o;
  logic [7:0]  data_byte_o;
  logic [11:0] byte_index_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i;

  // Predicted parser state and length limit.
  phase_e      p_phase;
  int unsigned p_hdr_cnt;
  logic [31:0] p_id;
  logic [31:0] p_len;
  logic [11:0] p_cnt;
  bit          p_halted;
  logic [11:0] p_max_len;

  frame_event_t pending_events[$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned parsed_bytes;
  int unsigned limit_writes;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  framed_message_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .msg_id_o      (msg_id_o),
    .content_len_o (content_len_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MaxCycles) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic void clear_parser();
    p_phase   = PH_START;
    p_hdr_cnt = 0;
    p_id      = '0;
    p_len     = '0;
    p_cnt     = '0;
    p_halted  = 1'b0;
  endfunction

  // Advances the predicted parser by one item; returns 1 when it yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic rs,
                                    output frame_event_t ev);
    logic [11:0] idx;
    ev = '0;
    if (rs) begin
      clear_parser();
      return 1'b0;
    end
    if (p_halted) return 1'b0;
    case (p_phase)
      PH_START: begin
        if (b == StartByte) begin
          p_phase   = PH_HEADER;
          p_hdr_cnt = 0;
          p_id      = '0;
          p_len     = '0;
          p_cnt     = '0;
          return 1'b0;
        end
        p_halted = 1'b1;
        if (b == CloseByte) begin
          ev.code = EV_CLOSE;
        end else begin
          ev.code = EV_BAD_START;
          ev.data = b;
        end
        return 1'b1;
      end
      PH_HEADER: begin
        if (p_hdr_cnt < 4) p_id = {p_id[23:0], b};
        else p_len = {p_len[23:0], b};
        p_hdr_cnt++;
        if (p_hdr_cnt < 8) return 1'b0;
        ev.id  = p_id;
        ev.len = p_len;
        if (p_len > 32'(p_max_len) || p_len > BufLimit) begin
          p_halted = 1'b1;
          ev.code  = EV_TOO_LONG;
          return 1'b1;
        end
        p_cnt   = '0;
        p_phase = (p_len == 0) ? PH_END : PH_CONTENT;
        ev.code = EV_HEADER_DONE;
        return 1'b1;
      end
      PH_CONTENT: begin
        idx   = p_cnt;
        p_cnt = p_cnt + 12'd1;
        if (32'(idx) + 32'd1 >= p_len) p_phase = PH_END;
        ev.code = EV_CONTENT;
        ev.id   = p_id;
        ev.len  = p_len;
        ev.data = b;
        ev.idx  = idx;
        return 1'b1;
      end
      default: begin
        if (b == EndByte) begin
          ev.code   = EV_MSG_DONE;
          ev.id     = p_id;
          ev.len    = p_len;
          p_phase   = PH_START;
          p_hdr_cnt = 0;
          p_cnt     = '0;
          return 1'b1;
        end
        p_halted = 1'b1;
        ev.code  = EV_BAD_END;
        ev.data  = b;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    frame_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing expected: event_res %0d", event_res_o);
        errors++;
      end else begin
        want = pending_events.pop_front();
        results_checked++;
        check_field("event_res", 32'(want.code), 32'(event_res_o));
        check_field("msg_id", want.id, msg_id_o);
        check_field("content_len", want.len, content_len_o);
        check_field("data_byte", 32'(want.data), 32'(data_byte_o));
        check_field("byte_index", 32'(want.idx), 32'(byte_index_o));
      end
    end
  end

  // Presents one item and returns at the edge where it is taken. Valid stays
  // high afterwards until the next call or a settle at the following falling edge.
  task automatic send_item(input logic [7:0] b, input logic rs);
    frame_event_t ev;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!rs && !p_halted) parsed_bytes++;
    if (parse_byte(b, rs, ev)) pending_events.push_back(ev);
  endtask

  task automatic send_header(input logic [31:0] id, input logic [31:0] len);
    logic [63:0] hdr;
    hdr = {id, len};
    send_item(StartByte, 1'b0);
    repeat (8) begin
      send_item(hdr[63:56], 1'b0);
      hdr = hdr << 8;
    end
  endtask

  task automatic send_content(input int unsigned n);
    repeat (n) send_item(8'($urandom_range(255)), 1'b0);
  endtask

  // Drops valid, drains all expected results and lets the pipeline empty.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [11:0] lim);
    settle_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    p_max_len = lim;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_frames();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // All-ones identifier with a single all-ones content byte.
    send_header(32'hFFFF_FFFF, 32'd1);
    send_item(8'hFF, 1'b0);
    send_item(EndByte, 1'b0);
    // Zero length: the end byte follows the header directly, here a wrong one.
    send_header(32'h0000_0000, 32'd0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    // A close byte ends the session; later bytes are ignored until restart.
    send_item(CloseByte, 1'b0);
    send_item(StartByte, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_length_limit();
    logic [11:0] lims[5];
    logic [31:0] big;
    lims = '{12'd0, 12'd1, 12'd7, 12'(BufLimit), 12'($urandom_range(2, 4085))};
    foreach (lims[i]) begin
      write_limit(lims[i]);
      // A length equal to the limit is still accepted.
      send_header($urandom, 32'(lims[i]));
      if (lims[i] <= 16) begin
        send_content(lims[i]);
        send_item(EndByte, 1'b0);
      end else begin
        send_content(3);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      send_header($urandom, 32'(lims[i]) + 32'd1);
      send_item(8'($urandom_range(255)), 1'b1);
      big = $urandom | 32'h8000_0000;
      send_header($urandom, big);
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned src,
                                     input int unsigned sink, input logic [11:0] lim);
    int unsigned goal;
    int unsigned roll;
    int unsigned len;
    logic [7:0]  b;
    logic [31:0] big;
    write_limit(lim);
    src_idle_pct   = src;
    sink_stall_pct = sink;
    goal = parsed_bytes + n_items;
    while (parsed_bytes < goal) begin
      roll = $urandom_range(99);
      len  = $urandom_range(99);
      if (len < 10) len = 0;
      else if (len < 85) len = $urandom_range(1, 8);
      else if (len < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 300);
      if (len > p_max_len) len = p_max_len;
      if (roll < 70) begin
        send_header($urandom, len);
        send_content(len);
        send_item(EndByte, 1'b0);
      end else if (roll < 76) begin
        b = 8'($urandom_range(255));
        if (b == StartByte) b = ~b;
        if ($urandom_range(3) == 0) b = CloseByte;
        send_item(b, 1'b0);
      end else if (roll < 82) begin
        send_header($urandom, len);
        send_content(len);
        b = 8'($urandom_range(255));
        if (b == EndByte) b = b ^ 8'h01;
        send_item(b, 1'b0);
      end else if (roll < 88) begin
        big = $urandom;
        if (big <= 32'(p_max_len)) big = 32'(p_max_len) + 32'($urandom_range(1, 3));
        send_header($urandom, big);
      end else if (roll < 94) begin
        // Connection drops mid-frame, either in the header or in the content.
        if ($urandom_range(1) == 0 || p_max_len < 2) begin
          send_item(StartByte, 1'b0);
          send_content($urandom_range(0, 7));
        end else begin
          len = $urandom_range(2, (p_max_len < 20) ? p_max_len : 20);
          send_header($urandom, len);
          send_content($urandom_range(0, len - 1));
        end
        send_item(8'($urandom_range(255)), 1'b1);
      end else begin
        send_item(8'($urandom_range(255)), 1'b1);
      end
      if (p_halted) begin
        send_content($urandom_range(0, 3));
        send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    restart_i      = 1'b0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    p_max_len      = (BufLimit > 4095) ? 12'd4095 : 12'(BufLimit);
    clear_parser();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_length_limit();
    test_random_traffic(180, 0, 0, 12'(BufLimit));
    test_random_traffic(180, 88, 0, 12'($urandom_range(16, 64)));
    test_random_traffic(180, 0, 88, 12'($urandom_range(8, 4086)));
    test_random_traffic(180, 15, 15, 12'(BufLimit));
    settle_idle();

    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      errors++;
    end
    $display("Parsed %0d frame bytes under %0d length-limit settings, with gaps on both sides.",
             parsed_bytes, limit_writes);
    $display("Compared %0d results field by field, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
